/* rtl/bscf_pkg.sv */
// Shared types and constants for the state-of-charge swing filter.
`timescale 1ns / 1ps
`default_nettype none

package bscf_pkg;

    // Field widths
    localparam int SocW   = 8;
    localparam int FracW  = 8;
    localparam int CapW   = 7;
    localparam int CountW = 8;
    localparam int LimW   = 8;
    localparam int BandW  = 7;
    localparam int PctW   = 7;

    // Stream packing
    localparam int InDataW  = 24;
    localparam int OutDataW = 16;

    // Configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;

    localparam logic [CfgIdxW-1:0] RegErrorLimit = 2'd0;
    localparam logic [CfgIdxW-1:0] RegZeroLimit  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegSwingLow   = 2'd2;
    localparam logic [CfgIdxW-1:0] RegSwingHigh  = 2'd3;

    // Reset values
    localparam logic [LimW-1:0]   ErrorLimitRst = 8'd5;
    localparam logic [LimW-1:0]   ZeroLimitRst  = 8'd225;
    localparam logic [BandW-1:0]  SwingLowRst   = 7'd30;
    localparam logic [BandW-1:0]  SwingHighRst  = 7'd70;
    localparam logic [CapW-1:0]   CapacityRst   = 7'd1;

    // Full charge and counter ceiling
    localparam logic [SocW-1:0]   SocFull  = 8'd100;
    localparam logic [CountW-1:0] CountMax = 8'd255;

    // Live configuration
    typedef struct packed {
        logic [LimW-1:0]  error_limit;
        logic [LimW-1:0]  zero_limit;
        logic [BandW-1:0] swing_low;
        logic [BandW-1:0] swing_high;
    } cfg_t;

    // One gauge reading
    typedef struct packed {
        logic [SocW-1:0]  soc_integer;
        logic [FracW-1:0] soc_fraction;
        logic             stat_pin;
        logic             usb_pin;
    } reading_t;

    // One filtered result
    typedef struct packed {
        logic [CapW-1:0] capacity_out;
        logic            charging_out;
        logic            restart_request;
        logic            reading_invalid;
    } result_t;

    // Saturating increment
    function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
        return (c < CountMax) ? c + 1'b1 : CountMax;
    endfunction

endpackage

`default_nettype wire

/* rtl/bscf_cfg_regs.sv */
// Configuration register file for the swing filter.
`timescale 1ns / 1ps
`default_nettype none

module bscf_cfg_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bscf_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [bscf_pkg::CfgDataW-1:0] cfg_wdata,
    output bscf_pkg::cfg_t                     cfg
);

    bscf_pkg::cfg_t cfg_reg;

    // Indexed writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.error_limit <= bscf_pkg::ErrorLimitRst;
            cfg_reg.zero_limit  <= bscf_pkg::ZeroLimitRst;
            cfg_reg.swing_low   <= bscf_pkg::SwingLowRst;
            cfg_reg.swing_high  <= bscf_pkg::SwingHighRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bscf_pkg::RegErrorLimit: cfg_reg.error_limit <= cfg_wdata;
                bscf_pkg::RegZeroLimit:  cfg_reg.zero_limit  <= cfg_wdata;
                bscf_pkg::RegSwingLow:   cfg_reg.swing_low   <= cfg_wdata[bscf_pkg::BandW-1:0];
                bscf_pkg::RegSwingHigh:  cfg_reg.swing_high  <= cfg_wdata[bscf_pkg::BandW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/bscf_in_reg.sv */
// Input register stage: captures one reading beat per cycle unless the filter stalls the held beat.
`timescale 1ns / 1ps
`default_nettype none

module bscf_in_reg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [bscf_pkg::InDataW-1:0]   s_axis_tdata,
    input  wire logic                           advance,
    output logic                                rd_valid,
    output bscf_pkg::reading_t                  rd
);

    logic               valid_reg;
    bscf_pkg::reading_t rd_reg;

    // Free when empty or when the held beat moves on this cycle
    assign s_axis_tready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // Payload unpack, lowest field first
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            rd_reg.soc_integer  <= s_axis_tdata[7:0];
            rd_reg.soc_fraction <= s_axis_tdata[15:8];
            rd_reg.stat_pin     <= s_axis_tdata[16];
            rd_reg.usb_pin      <= s_axis_tdata[17];
        end
    end

    assign rd_valid = valid_reg;
    assign rd       = rd_reg;

endmodule

`default_nettype wire

/* rtl/bscf_filter.sv */
// Filter state, update logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module bscf_filter
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  bscf_pkg::cfg_t             cfg,
    input  wire logic                  rd_valid,
    input  bscf_pkg::reading_t         rd,
    output logic                       advance,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output bscf_pkg::result_t          res
);

    logic [bscf_pkg::CapW-1:0]   capacity_reg, capacity_next;
    logic                        charging_reg, charging_next;
    logic [bscf_pkg::CountW-1:0] error_count_reg, error_count_next;
    logic [bscf_pkg::CountW-1:0] zero_count_reg, zero_count_next;
    logic                        out_valid_reg;
    bscf_pkg::result_t           out_reg, out_next;

    logic                        do_step;
    logic                        invalid;
    logic                        restart;
    logic [bscf_pkg::CountW-1:0] err_bumped, zero_bumped;
    logic [bscf_pkg::FracW+4:0]  frac_x25;
    logic [bscf_pkg::PctW-1:0]   pct;
    logic                        outside, near;
    logic [bscf_pkg::SocW:0]     soc_p1, cap_p1;

    // Result register frees when empty or taken
    assign advance = !out_valid_reg || res_ready;
    assign do_step = advance && rd_valid;

    // Fraction percent = frac*25 >> 6, as shift-adds
    assign frac_x25 = {1'b0, rd.soc_fraction, 4'b0} + {2'b0, rd.soc_fraction, 3'b0}
                    + {5'b0, rd.soc_fraction};
    assign pct      = frac_x25[bscf_pkg::FracW+4:6];

    // Fraction outside the band, reading within one of the held capacity
    assign outside = (pct > cfg.swing_high) || (pct < cfg.swing_low);

    assign soc_p1 = {1'b0, rd.soc_integer} + 1'b1;
    assign cap_p1 = {2'b0, capacity_reg} + 1'b1;

    assign near = (soc_p1 >= {2'b0, capacity_reg}) && ({1'b0, rd.soc_integer} <= cap_p1);

    assign err_bumped  = bscf_pkg::bump(error_count_reg);
    assign zero_bumped = bscf_pkg::bump(zero_count_reg);

    // Next state for one reading
    always_comb
    begin
        capacity_next    = capacity_reg;
        error_count_next = error_count_reg;
        zero_count_next  = zero_count_reg;
        restart          = 1'b0;
        invalid          = 1'b0;
        if (rd.soc_integer > bscf_pkg::SocFull)
        begin
            // Rejected reading: hold capacity, count errors
            invalid = 1'b1;
            if (err_bumped > cfg.error_limit)
            begin
                restart          = 1'b1;
                error_count_next = '0;
            end
            else
            begin
                error_count_next = err_bumped;
            end
        end
        else
        begin
            error_count_next = '0;
            // Zero readings while charging
            if (charging_reg && (rd.soc_integer == '0))
            begin
                if (zero_bumped > cfg.zero_limit)
                begin
                    restart         = 1'b1;
                    zero_count_next = '0;
                end
                else
                begin
                    zero_count_next = zero_bumped;
                end
            end
            else
            begin
                zero_count_next = '0;
            end
            // Swing suppression below full
            if ((rd.soc_integer < bscf_pkg::SocFull) && outside && near)
            begin
                capacity_next = capacity_reg;
            end
            else
            begin
                capacity_next = rd.soc_integer[bscf_pkg::CapW-1:0];
            end
        end
        // Charging mode from pins and new capacity
        charging_next = !rd.stat_pin
                     || (rd.usb_pin && ({1'b0, capacity_next} < bscf_pkg::SocFull));

        out_next.capacity_out    = capacity_next;
        out_next.charging_out    = charging_next;
        out_next.restart_request = restart;
        out_next.reading_invalid = invalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= bscf_pkg::CapacityRst;
            charging_reg    <= 1'b0;
            error_count_reg <= '0;
            zero_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= rd_valid;
            end
            if (do_step)
            begin
                capacity_reg    <= capacity_next;
                charging_reg    <= charging_next;
                error_count_reg <= error_count_next;
                zero_count_reg  <= zero_count_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

/* rtl/battery_soc_capacity_filter_core.sv */
// Top level of the state-of-charge swing filter.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | s_axis_tdata[23:0], one gauge reading
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | m_axis_tdata[15:0], one filtered result
//  cfg      | in  | cfg_we                       | cfg_index[1:0], cfg_wdata[7:0]
//
// One reading per cycle sustained while m_axis is not stalled; a reading passes the input and result registers.
// The path is the input register, the compare/count update and the result register.
// rst_n clears state to capacity 1, not charging, counters zero, limits to defaults.
// A stall on m_axis fills the input register, then holds s_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none

module battery_soc_capacity_filter_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // soc_integer[7:0], soc_fraction[15:8], stat_pin[16], usb_pin[17], zero[23:18]
    input  wire logic [bscf_pkg::InDataW-1:0]  s_axis_tdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // capacity_out[6:0], charging_out[7], restart_request[8], reading_invalid[9], zero[15:10]
    output logic [bscf_pkg::OutDataW-1:0]      m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic                          cfg_we,
    input  wire logic [bscf_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [bscf_pkg::CfgDataW-1:0] cfg_wdata
);

    bscf_pkg::cfg_t     cfg;
    bscf_pkg::reading_t rd;
    bscf_pkg::result_t  res;
    logic               rd_valid;
    logic               advance;

    bscf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bscf_in_reg u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .rd_valid      (rd_valid),
        .rd            (rd)
    );

    bscf_filter u_filt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rd_valid  (rd_valid),
        .rd        (rd),
        .advance   (advance),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Result packing, lowest field first
    assign m_axis_tdata = {6'b0, res.reading_invalid, res.restart_request,
                           res.charging_out, res.capacity_out};

endmodule

`default_nettype wire

/* rtl/bscf_checker.sv */
// Port-level checks for the swing filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bscf_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic [bscf_pkg::InDataW-1:0]  s_axis_tdata,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [bscf_pkg::OutDataW-1:0] m_axis_tdata,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

    // Capacity never above full, padding stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= 7'd100) && (m_axis_tdata[15:10] == 6'd0))
        else $error("result capacity out of range or padding set");

    // A fresh result follows an accepted input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a matching reading");

    // Input back-pressure only comes from a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output free");

endmodule

bind battery_soc_capacity_filter_core bscf_checker u_bscf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
